/* rtl/core/bvg_pkg.sv */
`timescale 1ns / 1ps
package bvg_pkg;

	localparam int SAMPLE_W  = 12;
	localparam int SUM_W     = 18;
	localparam int MV_W      = 16;
	localparam int PCT_W     = 7;
	localparam int DIV_W     = 24;
	localparam int DSR_W     = 16;
	localparam int CRIT_W    = 20;
	localparam int ADDR_W    = 4;
	localparam int DATA_W    = 32;

	localparam int SAMPLES_DEFAULT = 8;
	localparam int PRESENT_MV      = 2500;
	localparam int CRIT_DIV        = 10;
	localparam int FULL_PCT        = 100;
	localparam int MV_SAT          = 65535;

	// register indexes (byte address / 4)
	localparam logic [1:0] REG_EMPTY_MV = 2'd0;
	localparam logic [1:0] REG_FULL_MV  = 2'd1;
	localparam logic [1:0] REG_RATIO    = 2'd2;

	typedef struct packed {
		logic [MV_W-1:0]  empty_mv;
		logic [MV_W-1:0]  full_mv;
		logic [PCT_W-1:0] ratio_high_pct;
	} cfg_t;

	typedef struct packed {
		logic take;
		logic latch_avg;
		logic start_mv;
		logic latch_mv;
		logic start_pct;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic last;
		logic div_done;
		logic div_busy;
	} sts_t;

endpackage

/* rtl/core/bvg_regs.sv */
`timescale 1ns / 1ps
module bvg_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [bvg_pkg::ADDR_W-1:0] paddr,
	input  logic [bvg_pkg::DATA_W-1:0] pwdata,
	output logic [bvg_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	output bvg_pkg::cfg_t              cfg
);
	import bvg_pkg::*;

	cfg_t       cfg_q;
	logic [1:0] reg_idx;
	logic       wr_en;

	assign reg_idx = paddr[ADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				REG_EMPTY_MV: cfg_q.empty_mv       <= pwdata[MV_W-1:0];
				REG_FULL_MV:  cfg_q.full_mv        <= pwdata[MV_W-1:0];
				REG_RATIO:    cfg_q.ratio_high_pct <= pwdata[PCT_W-1:0];
				default:      ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_EMPTY_MV: prdata = DATA_W'(cfg_q.empty_mv);
			REG_FULL_MV:  prdata = DATA_W'(cfg_q.full_mv);
			REG_RATIO:    prdata = DATA_W'(cfg_q.ratio_high_pct);
			default:      prdata = '0;
		endcase
	end

endmodule

/* rtl/core/bvg_div.sv */
`timescale 1ns / 1ps
module bvg_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [bvg_pkg::DIV_W-1:0] dividend,
	input  logic [bvg_pkg::DSR_W-1:0] divisor,
	output logic [bvg_pkg::DIV_W-1:0] quotient,
	output logic                      busy,
	output logic                      done
);
	import bvg_pkg::*;

	localparam int CNT_W = $clog2(DIV_W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DIV_W-1:0] dvd_q;
	logic [DSR_W-1:0] rem_q;
	logic [DSR_W-1:0] dsr_q;
	logic [DSR_W:0]   rem_sh;
	logic [DSR_W:0]   rem_sub;
	logic             ge;

	// restoring division, one quotient bit per cycle
	assign rem_sh  = {rem_q, dvd_q[DIV_W-1]};
	assign rem_sub = rem_sh - {1'b0, dsr_q};
	assign ge      = rem_sh >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(1));
			if (start) begin
				cnt_q  <= CNT_W'(DIV_W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q  <= cnt_q - CNT_W'(1);
				busy_q <= cnt_q != CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DIV_W-2:0], ge};
			rem_q <= ge ? rem_sub[DSR_W-1:0] : rem_sh[DSR_W-1:0];
		end
	end

	assign quotient = dvd_q;
	assign busy     = busy_q;
	assign done     = done_q;

endmodule

/* rtl/core/bvg_dpath.sv */
`timescale 1ns / 1ps
module bvg_dpath #(
	parameter int SAMPLES_PER_READING = bvg_pkg::SAMPLES_DEFAULT
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [bvg_pkg::SAMPLE_W-1:0] sample_mv,
	input  bvg_pkg::cfg_t                cfg,
	input  bvg_pkg::cmd_t                cmd,
	output bvg_pkg::sts_t                sts,
	output logic [bvg_pkg::MV_W-1:0]     battery_mv,
	output logic [bvg_pkg::PCT_W-1:0]    charge_pct,
	output logic                         present,
	output logic                         critical,
	output logic                         config_valid
);
	import bvg_pkg::*;

	localparam int CNT_W = $clog2(SAMPLES_PER_READING + 1);

	// floor(sum / N) as (sum * ceil(2^S / N)) >> S, exact for every sum below 2^SUM_W
	localparam int     AVG_SHIFT = SUM_W + $clog2(SAMPLES_PER_READING);
	localparam int     RECIP_W   = AVG_SHIFT + 1;
	localparam int     PROD_W    = SUM_W + RECIP_W;
	localparam longint AVG_RECIP = ((longint'(1) << AVG_SHIFT) +
		longint'(SAMPLES_PER_READING) - longint'(1)) / longint'(SAMPLES_PER_READING);

	logic [CNT_W-1:0]    count_q;
	logic [SUM_W-1:0]    sum_q;
	logic [SUM_W-1:0]    sum_nxt;
	logic [PROD_W-1:0]   avg_prod;
	logic [SAMPLE_W-1:0] avg_q;
	logic [MV_W-1:0]     mv_q;
	logic [MV_W-1:0]     span;
	logic [DIV_W-1:0]    div_dvd;
	logic [DSR_W-1:0]    div_dsr;
	logic [DIV_W-1:0]    div_quot;
	logic                div_start;
	logic                div_busy;
	logic                div_done;
	logic                cfg_ok;
	logic                pres;
	logic                crit;
	logic [PCT_W-1:0]    pct;
	logic [CRIT_W-1:0]   crit_lhs;
	logic [CRIT_W-1:0]   crit_rhs;
	logic [MV_W-1:0]     battery_mv_q;
	logic [PCT_W-1:0]    charge_pct_q;
	logic                present_q;
	logic                critical_q;
	logic                config_valid_q;

	assign sum_nxt  = sum_q + SUM_W'(sample_mv);
	assign sts.last = count_q == CNT_W'(SAMPLES_PER_READING - 1);
	assign span     = cfg.full_mv - cfg.empty_mv;
	assign avg_prod = PROD_W'(sum_nxt) * PROD_W'(AVG_RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q   <= '0;
		end else if (cmd.take) begin
			if (sts.last) begin
				count_q <= '0;
				sum_q   <= '0;
			end else begin
				count_q <= count_q + CNT_W'(1);
				sum_q   <= sum_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_avg) begin
			avg_q <= avg_prod[AVG_SHIFT +: SAMPLE_W];
		end
	end

	// operand select for the shared divider
	assign div_start = cmd.start_mv || cmd.start_pct;

	always_comb begin
		if (cmd.start_mv) begin
			div_dvd = DIV_W'(avg_q) * DIV_W'(FULL_PCT);
			div_dsr = DSR_W'(PCT_W'(FULL_PCT) - cfg.ratio_high_pct);
		end else begin
			div_dvd = (mv_q > cfg.empty_mv) ?
				DIV_W'(mv_q - cfg.empty_mv) * DIV_W'(FULL_PCT) : '0;
			div_dsr = span;
		end
	end

	bvg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dsr),
		.quotient (div_quot),
		.busy     (div_busy),
		.done     (div_done)
	);

	assign sts.div_done = div_done;
	assign sts.div_busy = div_busy;

	always_ff @(posedge clk) begin
		if (cmd.latch_mv) begin
			mv_q <= (div_quot > DIV_W'(MV_SAT)) ? MV_W'(MV_SAT) : div_quot[MV_W-1:0];
		end
	end

	// final flags and percent, quotient holds the percent division here
	always_comb begin
		cfg_ok   = (cfg.full_mv > cfg.empty_mv) && (cfg.ratio_high_pct != '0) &&
			(cfg.ratio_high_pct < PCT_W'(FULL_PCT));
		pres     = mv_q > MV_W'(PRESENT_MV);
		crit_lhs = CRIT_W'(mv_q) * CRIT_W'(CRIT_DIV);
		crit_rhs = CRIT_W'(cfg.empty_mv) * CRIT_W'(CRIT_DIV) + CRIT_W'(span);
		crit     = pres && (crit_lhs <= crit_rhs);
		if (!pres || mv_q <= cfg.empty_mv) begin
			pct = '0;
		end else if (mv_q >= cfg.full_mv) begin
			pct = PCT_W'(FULL_PCT);
		end else begin
			pct = div_quot[PCT_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			battery_mv_q   <= cfg_ok ? mv_q : '0;
			charge_pct_q   <= cfg_ok ? pct : '0;
			present_q      <= cfg_ok && pres;
			critical_q     <= cfg_ok && crit;
			config_valid_q <= cfg_ok;
		end
	end

	assign battery_mv   = battery_mv_q;
	assign charge_pct   = charge_pct_q;
	assign present      = present_q;
	assign critical     = critical_q;
	assign config_valid = config_valid_q;

endmodule

/* rtl/core/bvg_ctrl.sv */
`timescale 1ns / 1ps
module bvg_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	input  bvg_pkg::sts_t sts,
	output bvg_pkg::cmd_t cmd
);
	import bvg_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_AVG,
		S_MV,
		S_PREP,
		S_PCT,
		S_PUSH
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign in_stall  = state_q != S_IDLE;
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;

	always_comb begin
		cmd           = '0;
		cmd.take      = in_valid && (state_q == S_IDLE);
		cmd.latch_avg = cmd.take && sts.last;
		cmd.start_mv  = state_q == S_AVG;
		cmd.latch_mv  = (state_q == S_MV) && sts.div_done;
		cmd.start_pct = state_q == S_PREP;
		cmd.load_out  = (state_q == S_PUSH) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: if (cmd.latch_avg) state_q <= S_AVG;
				S_AVG:  state_q <= S_MV;
				S_MV:   if (sts.div_done) state_q <= S_PREP;
				S_PREP: state_q <= S_PCT;
				S_PCT:  if (sts.div_done) state_q <= S_PUSH;
				S_PUSH: if (out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* rtl/core/battery_voltage_gauge.sv */
`timescale 1ns / 1ps
// Battery voltage gauge.
// Input channel (in_valid / in_stall / sample_mv): one converter reading per
// request. Readings that do not close a group are taken back to back. Every
// SAMPLES_PER_READING-th reading closes a group: its average comes from a
// reciprocal multiply in the cycle it is taken, then the divider scaling and
// the percent run through one shared one-bit-per-cycle divider (24 steps
// each). The result request is loaded onto out_valid after both divisions,
// once the output register is free. The input is held in stall while the
// group is worked out, so the next reading is taken only once the result is
// loaded; the two serial divisions take most of that time.
// Output channel (out_valid / out_stall / battery_mv ... config_valid): one
// request per group. While out_stall is high the result request stays in
// its output register and readings of the next group are still taken; only
// the result of a further group waits until the pending result is gone.
// Configuration: APB writes to empty_mv (0x0), full_mv (0x4) and
// ratio_high_pct (0x8), write only while the block is idle. A bad range or
// ratio gives an all-zero result with config_valid low.
// Reset clears the registers, the running sum and count, and drops out_valid.
module battery_voltage_gauge #(
	parameter int SAMPLES_PER_READING = bvg_pkg::SAMPLES_DEFAULT
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [bvg_pkg::ADDR_W-1:0]   paddr,
	input  logic [bvg_pkg::DATA_W-1:0]   pwdata,
	output logic [bvg_pkg::DATA_W-1:0]   prdata,
	output logic                         pready,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [bvg_pkg::SAMPLE_W-1:0] sample_mv,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [bvg_pkg::MV_W-1:0]     battery_mv,
	output logic [bvg_pkg::PCT_W-1:0]    charge_pct,
	output logic                         present,
	output logic                         critical,
	output logic                         config_valid
);
	import bvg_pkg::*;

	cfg_t cfg;
	cmd_t cmd;
	sts_t sts;

	// register file on the APB side
	bvg_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// sequence: accumulate, average, scale, percent, push
	bvg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// accumulator, shared divider, flag logic and output register
	bvg_dpath #(
		.SAMPLES_PER_READING (SAMPLES_PER_READING)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_mv    (sample_mv),
		.cfg          (cfg),
		.cmd          (cmd),
		.sts          (sts),
		.battery_mv   (battery_mv),
		.charge_pct   (charge_pct),
		.present      (present),
		.critical     (critical),
		.config_valid (config_valid)
	);

	// a new result never overwrites one that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid || !out_stall))
		else $error("result loaded over a pending request");

	// a group end locks the input until its result is formed
	a_group_end_locks: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && sts.last) |=> in_stall)
		else $error("input taken right after a group end");

	// the divider only runs while readings are held off
	a_div_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		sts.div_busy |-> in_stall)
		else $error("reading accepted while divider busy");

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps
// Self-checking bench for the battery voltage gauge.
// Every accepted sample request is folded into a local copy of the running group.
// Each group end queues the reading that the gauge must return. Output requests
// are popped and compared field by field.
module testbench;
	import bvg_pkg::*;

	localparam int GROUP_LEN   = 8;
	// the group-end work spans both divisions plus output stalls; leave margin
	localparam int SETTLE_CYC  = 100;
	localparam int CYCLE_LIMIT = 300000;
	localparam int PHASE_ITEMS = 70;
	localparam int NUM_PHASES  = 10;
	localparam int HOLD_CYC    = 600;
	localparam int TAP_MAX     = (1 << SAMPLE_W) - 1;

	typedef struct packed {
		logic [MV_W-1:0]  mv;
		logic [PCT_W-1:0] pct;
		logic             present;
		logic             critical;
		logic             config_valid;
	} reading_t;

	// one directed request; a typed reading replaces the prediction at a group end
	typedef struct packed {
		logic [SAMPLE_W-1:0] sample;
		logic                new_cfg;
		cfg_t                cfg;
		logic                typed;
		reading_t            want;
	} dir_row_t;

	localparam cfg_t     CFG_NONE  = '0;
	localparam cfg_t     CFG_LIION = '{16'd3000, 16'd4200, 7'd50};
	localparam cfg_t     CFG_STEEP = '{16'd3000, 16'd4200, 7'd99};
	localparam reading_t NO_WANT   = '0;

	// reset config is unusable (zero range, zero ratio), then an all-zero
	// group, then a full-scale group through a 99 percent divider that saturates
	localparam dir_row_t DIR_ROWS [24] = '{
		'{12'd4095, 1'b0, CFG_NONE,  1'b0, NO_WANT},
		'{12'd4095, 1'b0, CFG_NONE,  1'b0, NO_WANT},
		'{12'd4095, 1'b0, CFG_NONE,  1'b0, NO_WANT},
		'{12'd4095, 1'b0, CFG_NONE,  1'b0, NO_WANT},
		'{12'd4095, 1'b0, CFG_NONE,  1'b0, NO_WANT},
		'{12'd4095, 1'b0, CFG_NONE,  1'b0, NO_WANT},
		'{12'd4095, 1'b0, CFG_NONE,  1'b0, NO_WANT},
		'{12'd4095, 1'b0, CFG_NONE,  1'b1, '{16'd0, 7'd0, 1'b0, 1'b0, 1'b0}},
		'{12'd0,    1'b1, CFG_LIION, 1'b0, NO_WANT},
		'{12'd0,    1'b0, CFG_NONE,  1'b0, NO_WANT},
		'{12'd0,    1'b0, CFG_NONE,  1'b0, NO_WANT},
		'{12'd0,    1'b0, CFG_NONE,  1'b0, NO_WANT},
		'{12'd0,    1'b0, CFG_NONE,  1'b0, NO_WANT},
		'{12'd0,    1'b0, CFG_NONE,  1'b0, NO_WANT},
		'{12'd0,    1'b0, CFG_NONE,  1'b0, NO_WANT},
		'{12'd0,    1'b0, CFG_NONE,  1'b1, '{16'd0, 7'd0, 1'b0, 1'b0, 1'b1}},
		'{12'd4095, 1'b1, CFG_STEEP, 1'b0, NO_WANT},
		'{12'd4095, 1'b0, CFG_NONE,  1'b0, NO_WANT},
		'{12'd4095, 1'b0, CFG_NONE,  1'b0, NO_WANT},
		'{12'd4095, 1'b0, CFG_NONE,  1'b0, NO_WANT},
		'{12'd4095, 1'b0, CFG_NONE,  1'b0, NO_WANT},
		'{12'd4095, 1'b0, CFG_NONE,  1'b0, NO_WANT},
		'{12'd4095, 1'b0, CFG_NONE,  1'b0, NO_WANT},
		'{12'd4095, 1'b0, CFG_NONE,  1'b1, '{16'd65535, 7'd100, 1'b1, 1'b0, 1'b1}}
	};

	// random phases: a typical pack, the widest range, every unusable
	// case (equal, inverted, ratio zero, 100 and 127), a high-voltage window;
	// the last entry is replaced by a random usable setting
	localparam cfg_t PHASE_CFG [NUM_PHASES] = '{
		'{16'd3000,  16'd4200,  7'd50},
		'{16'd0,     16'd65535, 7'd1},
		'{16'd3300,  16'd3300,  7'd50},
		'{16'd4200,  16'd3000,  7'd50},
		'{16'd3000,  16'd4200,  7'd0},
		'{16'd3000,  16'd4200,  7'd100},
		'{16'd3000,  16'd4200,  7'd127},
		'{16'd60000, 16'd65535, 7'd99},
		'{16'd2000,  16'd12000, 7'd75},
		'{16'd3000,  16'd4200,  7'd50}
	};

	logic                clk          = 1'b0;
	logic                arst_n       = 1'b0;
	logic                psel         = 1'b0;
	logic                penable      = 1'b0;
	logic                pwrite       = 1'b0;
	logic [ADDR_W-1:0]   paddr        = '0;
	logic [DATA_W-1:0]   pwdata       = '0;
	logic [DATA_W-1:0]   prdata;
	logic                pready;
	logic                in_valid     = 1'b0;
	logic                in_stall;
	logic [SAMPLE_W-1:0] sample_mv    = '0;
	logic                out_valid;
	logic                out_stall    = 1'b0;
	logic [MV_W-1:0]     battery_mv;
	logic [PCT_W-1:0]    charge_pct;
	logic                present;
	logic                critical;
	logic                config_valid;

	// local copy of the registers and of the running group
	cfg_t             cfg      = '0;
	logic [SUM_W-1:0] grp_sum  = '0;
	int unsigned      grp_cnt  = 0;
	reading_t         pending_readings [$];

	// shape of the group being generated
	int unsigned grp_style = 0;
	int unsigned grp_tap   = 0;

	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned hold_req      = 0;
	int unsigned hold_left     = 0;
	int unsigned cycle_cnt     = 0;
	int unsigned mismatches    = 0;

	battery_voltage_gauge #(
		.SAMPLES_PER_READING(GROUP_LEN)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.sample_mv   (sample_mv),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.battery_mv  (battery_mv),
		.charge_pct  (charge_pct),
		.present     (present),
		.critical    (critical),
		.config_valid(config_valid)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Bail out if the gauge hangs.
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("** battery_voltage_gauge: FAILED **");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		$display("MISMATCH %s: got %0d, expected %0d (cycle %0d)", what, got, want, cycle_cnt);
		mismatches++;
	endtask

	function automatic bit cfg_usable();
		return cfg.full_mv > cfg.empty_mv && cfg.ratio_high_pct != 0 &&
			cfg.ratio_high_pct < FULL_PCT;
	endfunction

	// Scale a completed group back through the divider and derive the flags.
	function automatic reading_t predict_reading(input logic [SUM_W-1:0] sum);
		int unsigned avg;
		int unsigned mv;
		int unsigned span;
		int unsigned pct;
		reading_t    r;
		r = '0;
		if (!cfg_usable())
			return r;
		span = 32'(cfg.full_mv) - 32'(cfg.empty_mv);
		avg  = sum / GROUP_LEN;
		mv   = avg * FULL_PCT / (FULL_PCT - cfg.ratio_high_pct);
		if (mv > MV_SAT)
			mv = MV_SAT;
		r.mv       = mv[MV_W-1:0];
		r.present  = mv > PRESENT_MV;
		// critical at or below a tenth of the range above empty_mv, compared without dividing
		r.critical = r.present && (mv * CRIT_DIV <= cfg.empty_mv * CRIT_DIV + span);
		if (!r.present || mv <= cfg.empty_mv)
			pct = 0;
		else if (mv >= cfg.full_mv)
			pct = FULL_PCT;
		else
			pct = (mv - cfg.empty_mv) * FULL_PCT / span;
		r.pct          = pct[PCT_W-1:0];
		r.config_valid = 1'b1;
		return r;
	endfunction

	// Fold one accepted request into the group; queue the reading at group end.
	function automatic void accumulate_sample(input logic [SAMPLE_W-1:0] s,
			input logic typed, input reading_t want);
		grp_sum = grp_sum + s;
		grp_cnt++;
		if (grp_cnt == GROUP_LEN) begin
			pending_readings.push_back(typed ? want : predict_reading(grp_sum));
			grp_sum = '0;
			grp_cnt = 0;
		end
	endfunction

	// Pick the next random sample. A group mostly clusters around a tap voltage
	// that lands on an interesting battery level; the rest is noise or rails.
	function automatic logic [SAMPLE_W-1:0] next_sample();
		int unsigned span;
		int unsigned lo;
		int unsigned hi;
		int unsigned tgt;
		int          v;
		if (grp_cnt == 0) begin
			grp_style = $urandom_range(99);
			if (cfg_usable()) begin
				span = 32'(cfg.full_mv) - 32'(cfg.empty_mv);
				case ($urandom_range(4))
					0: tgt = 32'(cfg.empty_mv);
					1: tgt = 32'(cfg.full_mv);
					2: tgt = cfg.empty_mv + span / CRIT_DIV;
					3: tgt = PRESENT_MV;
					default: begin
						lo = (cfg.empty_mv > span / 4) ? cfg.empty_mv - span / 4 : 0;
						hi = cfg.full_mv + span / 4;
						if (hi > MV_SAT)
							hi = MV_SAT;
						tgt = $urandom_range(hi, lo);
					end
				endcase
				grp_tap = tgt * (FULL_PCT - cfg.ratio_high_pct) / FULL_PCT;
				if (grp_tap > TAP_MAX)
					grp_tap = TAP_MAX;
			end else begin
				grp_tap = $urandom_range(TAP_MAX);
			end
		end
		if (grp_style < 60) begin
			v = int'(grp_tap) + int'($urandom_range(6)) - 3;
			if (v < 0)
				v = 0;
			if (v > TAP_MAX)
				v = TAP_MAX;
			return v[SAMPLE_W-1:0];
		end else if (grp_style < 85) begin
			return SAMPLE_W'($urandom_range(TAP_MAX));
		end
		return $urandom_range(1) ? TAP_MAX[SAMPLE_W-1:0] : '0;
	endfunction

	// Offer one request, idling beforehand at random; hold it until taken.
	task automatic send_sample(input logic [SAMPLE_W-1:0] s, input logic typed,
			input reading_t want);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid  <= 1'b1;
		sample_mv <= s;
		do @(posedge clk); while (in_stall);
		accumulate_sample(s, typed, want);
	endtask

	// Drop valid, wait for every queued reading, then let a partial group settle.
	task automatic settle_block();
		in_valid <= 1'b0;
		while (pending_readings.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	// APB write: setup cycle, then access until pready, then back to idle.
	task automatic write_reg(input logic [1:0] idx, input logic [DATA_W-1:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'({idx, 2'b00});
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// Write all three registers; junk in the upper bits must be masked off.
	task automatic write_cfg(input cfg_t c);
		logic [DATA_W-1:0] junk;
		junk = $urandom();
		write_reg(REG_EMPTY_MV, {junk[DATA_W-1:MV_W], c.empty_mv});
		write_reg(REG_FULL_MV,  {junk[MV_W-1:0], c.full_mv});
		write_reg(REG_RATIO,    {junk[DATA_W-1:PCT_W], c.ratio_high_pct});
		cfg = c;
	endtask

	// Receiver: stall at random, or for a long stretch when asked.
	always @(posedge clk) begin
		if (hold_req != 0) begin
			hold_left = hold_req;
			hold_req  = 0;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// Check every accepted result request against the oldest queued reading.
	always @(posedge clk) begin
		reading_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_readings.size() == 0) begin
				report_mismatch("unrequested reading, battery_mv", 32'(battery_mv), 0);
			end else begin
				want = pending_readings.pop_front();
				if (battery_mv !== want.mv)
					report_mismatch("battery_mv", 32'(battery_mv), 32'(want.mv));
				if (charge_pct !== want.pct)
					report_mismatch("charge_pct", 32'(charge_pct), 32'(want.pct));
				if (present !== want.present)
					report_mismatch("present", 32'(present), 32'(want.present));
				if (critical !== want.critical)
					report_mismatch("critical", 32'(critical), 32'(want.critical));
				if (config_valid !== want.config_valid)
					report_mismatch("config_valid", 32'(config_valid),
						32'(want.config_valid));
			end
		end
	end

	initial begin
		dir_row_t row;
		cfg_t     pc;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed table, sender barely idles and receiver stalls often
		send_idle_pct = 6;
		recv_idle_pct = 64;
		for (int i = 0; i < 24; i++) begin
			row = DIR_ROWS[i];
			if (row.new_cfg) begin
				settle_block();
				write_cfg(row.cfg);
			end
			send_sample(row.sample, row.typed, row.want);
		end

		// random phases, one register setting each
		for (int p = 0; p < NUM_PHASES; p++) begin
			settle_block();
			pc = PHASE_CFG[p];
			if (p == NUM_PHASES - 1) begin
				pc.empty_mv       = MV_W'($urandom_range(30000));
				pc.full_mv        = pc.empty_mv + MV_W'($urandom_range(20000, 1));
				pc.ratio_high_pct = PCT_W'($urandom_range(FULL_PCT - 1, 1));
			end
			write_cfg(pc);
			// swap who idles, then run with no idling at all
			if (p < 4) begin
				send_idle_pct = 6;
				recv_idle_pct = 64;
			end else if (p < 7) begin
				send_idle_pct = 64;
				recv_idle_pct = 6;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			// hold the output long enough that the gauge backs up into its input
			if (p == 8)
				hold_req = HOLD_CYC;
			repeat (PHASE_ITEMS) send_sample(next_sample(), 1'b0, NO_WANT);
		end

		settle_block();
		if (mismatches == 0) begin
			$display("** battery_voltage_gauge: PASSED **");
		end else begin
			$display("** battery_voltage_gauge: FAILED **");
		end
		$finish;
	end

endmodule

/* sim.f */
rtl/core/bvg_pkg.sv
rtl/core/bvg_regs.sv
rtl/core/bvg_div.sv
rtl/core/bvg_dpath.sv
rtl/core/bvg_ctrl.sv
rtl/core/battery_voltage_gauge.sv
bench/testbench.sv
